// ===== rtl/cci_pkg.sv =====
// Shared types and constants of the circle contact impulse resolver.
// No dependencies; imported by every module of the block.
package cci_pkg;

    // Width of the squared distance and of its integer root
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;

    // Stage control handed to each pipelined unit
    typedef struct packed {
        logic en;   // advance every stage this cycle
        logic vld;  // beat presented to the first stage
    } t_stage_ctl;

endpackage

// ===== rtl/circle_contact_impulse_resolver.sv =====
// Top level of the circle contact impulse resolver: stream ports, glue stages,
// square root and dividers. Depends on cci_pkg, cci_isqrt and cci_div.
//
//  channel | dir | handshake                        | payload
//  --------+-----+----------------------------------+----------------------------
//  s_axis  | in  | i_s_axis_tvalid/o_s_axis_tready  | pair geometry, masses, flags
//  m_axis  | out | o_m_axis_tvalid/i_m_axis_tready  | hit, depth, normal, pushes, kicks
//
// One beat enters per cycle unless the output stalls; the depth is set by the
// 33-stage root, the FRAC_BITS+2 stage normal divider (FRAC_BITS = 16 for
// Q16.16) and the 36-stage share divider. Reset is synchronous, active low,
// and clears only the valid bits. A stall on the output freezes every stage at
// once, so nothing is lost or repeated; bubbles travel as invalid stages.
module circle_contact_impulse_resolver
    import cci_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // rel_pos_x, rel_pos_y, rel_vel_x, rel_vel_y, radius_a, radius_b,
    // inv_mass_a, inv_mass_b, bounce_a, bounce_b, zero pad
    input  logic [287:0] i_s_axis_tdata,
    // dynamic_a, dynamic_b
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // depth, normal_x, normal_y, push_a_x, push_a_y, push_b_x, push_b_y,
    // kick_a_x, kick_a_y, kick_b_x, kick_b_y, zero pad
    output logic [327:0] o_m_axis_tdata,
    // hit
    output logic [0:0]   o_m_axis_tuser
);

    localparam int F          = FRAC_BITS;
    localparam int NMW        = F + 1;          // normal magnitude
    localparam int NSW        = F + 2;          // signed normal
    localparam int NUMW       = 32 + F;         // normal dividend
    localparam int SPW        = 32 + NSW;       // velocity times normal
    localparam int SSW        = SPW + 1;        // closing speed sum
    localparam int VW         = 33;
    localparam int EFW        = 18;
    localparam int QPW        = VW + EFW;
    localparam int QQW        = QPW - 16;       // impulse magnitude
    localparam int SHNW       = QQW + 31;       // share dividend
    localparam int GPW        = QQW + NMW;
    localparam int MW         = GPW - F;
    localparam int BOUNCE_ONE = 65536;
    localparam int SQS_W      = 274;
    localparam int NDS_W      = 210;
    localparam int SHS_W      = 2 * NSW + 2 * NMW + 33;

    // Saturated signed projection onto one normal axis
    function automatic logic [31:0] f_along(input logic [MW-1:0] m, input logic neg);
        logic [31:0] r;
        if (neg) begin
            if (m > MW'(32'h8000_0000)) r = 32'h8000_0000;
            else r = 32'd0 - m[31:0];
        end else begin
            if (m > MW'(32'h7FFF_FFFF)) r = 32'h7FFF_FFFF;
            else r = m[31:0];
        end
        return r;
    endfunction

    logic w_en;

    // Input fields
    logic [31:0] w_px, w_py, w_vx, w_vy;
    logic [30:0] w_ra, w_rb, w_ia, w_ib;
    logic [16:0] w_ba, w_bb;

    assign w_px = i_s_axis_tdata[31:0];
    assign w_py = i_s_axis_tdata[63:32];
    assign w_vx = i_s_axis_tdata[95:64];
    assign w_vy = i_s_axis_tdata[127:96];
    assign w_ra = i_s_axis_tdata[158:128];
    assign w_rb = i_s_axis_tdata[189:159];
    assign w_ia = i_s_axis_tdata[220:190];
    assign w_ib = i_s_axis_tdata[251:221];
    assign w_ba = i_s_axis_tdata[268:252];
    assign w_bb = i_s_axis_tdata[285:269];

    // Stage 0: magnitudes, sums
    logic [31:0] r_s0_pxm, r_s0_pym, r_s0_vx, r_s0_vy, r_s0_rsum, r_s0_tot;
    logic [30:0] r_s0_ia, r_s0_ib;
    logic [16:0] r_s0_e;
    logic        r_s0_pxn, r_s0_pyn, r_s0_dyn, r_s0_vld;

    // Stage 1: squares
    logic [63:0]      r_s1_sqx, r_s1_sqy;
    logic [SQS_W-1:0] r_s1_side;
    logic             r_s1_vld;

    // Root output
    t_stage_ctl       w_sq_ctl;
    logic             w_sq_vld;
    logic [31:0]      w_root;
    logic [SQS_W-1:0] w_sq_side;

    logic [31:0] h_pxm, h_pym, h_vx, h_vy, h_rsum, h_tot, h_diff;
    logic [30:0] h_ia, h_ib, h_depth;
    logic [16:0] h_e;
    logic        h_pxn, h_pyn, h_dyn, h_hit, h_zero;
    logic [1:0][NUMW-1:0] h_num;

    // Normal divider output
    t_stage_ctl           w_nd_ctl;
    logic                 w_nd_vld;
    logic [1:0][NMW-1:0]  w_nq;
    logic [NDS_W-1:0]     w_nd_side;

    logic signed [31:0]    a_vx, a_vy;
    logic [30:0]           a_ia, a_ib, a_depth;
    logic [31:0]           a_tot;
    logic [16:0]           a_e;
    logic                  a_pxn, a_pyn, a_hit, a_zero;
    logic [NMW-1:0]        a_nxm, a_nym;
    logic signed [NSW-1:0] a_nx, a_ny;
    logic signed [SPW-1:0] a_sx, a_sy;

    // Stage B: velocity projections
    logic signed [SPW-1:0] r_sb_sx, r_sb_sy;
    logic signed [NSW-1:0] r_sb_nx, r_sb_ny;
    logic [NMW-1:0]        r_sb_nxm, r_sb_nym;
    logic [30:0]           r_sb_ia, r_sb_ib, r_sb_depth;
    logic [31:0]           r_sb_tot;
    logic [16:0]           r_sb_e;
    logic                  r_sb_hit, r_sb_vld;

    logic signed [SSW-1:0] w_s;
    logic [SSW-1:0]        w_su, w_abs;

    // Stage C: closing speed
    logic [VW-1:0]         r_sc_v;
    logic [EFW-1:0]        r_sc_ef;
    logic                  r_sc_sep;
    logic signed [NSW-1:0] r_sc_nx, r_sc_ny;
    logic [NMW-1:0]        r_sc_nxm, r_sc_nym;
    logic [30:0]           r_sc_ia, r_sc_ib, r_sc_depth;
    logic [31:0]           r_sc_tot;
    logic                  r_sc_hit, r_sc_vld;

    // Stage D: restitution scaling
    logic [QPW-1:0]        r_sd_qp;
    logic                  r_sd_sep;
    logic signed [NSW-1:0] r_sd_nx, r_sd_ny;
    logic [NMW-1:0]        r_sd_nxm, r_sd_nym;
    logic [30:0]           r_sd_ia, r_sd_ib, r_sd_depth;
    logic [31:0]           r_sd_tot;
    logic                  r_sd_hit, r_sd_vld;

    logic [QQW-1:0]        w_q;
    logic [3:0][SHNW-1:0]  w_snum;

    // Share divider output
    t_stage_ctl            w_sd_ctl;
    logic                  w_sh_vld;
    logic [3:0][QQW-1:0]   w_g;
    logic [SHS_W-1:0]      w_sh_side;

    logic signed [NSW-1:0] e_nx, e_ny;
    logic [NMW-1:0]        e_nxm, e_nym;
    logic                  e_hit, e_sep;
    logic [30:0]           e_depth;
    logic [3:0][GPW-1:0]   w_epx, w_epy;

    // Stage E: projection products
    logic [3:0][GPW-1:0]   r_se_px, r_se_py;
    logic signed [NSW-1:0] r_se_nx, r_se_ny;
    logic                  r_se_hit, r_se_sep, r_se_vld;
    logic [30:0]           r_se_depth;

    logic signed [31:0]    w_nx32, w_ny32;
    logic [3:0][31:0]      w_ox, w_oy;
    logic [327:0]          n_out_data;

    // Output register
    logic [327:0]          r_out_data;
    logic                  r_out_hit, r_out_vld;

    // Every stage advances together unless the output beat is held
    assign w_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // Valid chain of the glue stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_sb_vld  <= 1'b0;
            r_sc_vld  <= 1'b0;
            r_sd_vld  <= 1'b0;
            r_se_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_s0_vld  <= i_s_axis_tvalid;
            r_s1_vld  <= r_s0_vld;
            r_sb_vld  <= w_nd_vld;
            r_sc_vld  <= r_sb_vld;
            r_sd_vld  <= r_sc_vld;
            r_se_vld  <= w_sh_vld;
            r_out_vld <= r_se_vld;
        end
    end

    // Stage 0 and 1: magnitudes, then squares
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_pxm  <= w_px[31] ? (32'd0 - w_px) : w_px;
            r_s0_pym  <= w_py[31] ? (32'd0 - w_py) : w_py;
            r_s0_pxn  <= w_px[31];
            r_s0_pyn  <= w_py[31];
            r_s0_vx   <= w_vx;
            r_s0_vy   <= w_vy;
            r_s0_rsum <= {1'b0, w_ra} + {1'b0, w_rb};
            r_s0_ia   <= w_ia;
            r_s0_ib   <= w_ib;
            r_s0_tot  <= {1'b0, w_ia} + {1'b0, w_ib};
            r_s0_e    <= 17'(({1'b0, w_ba} + {1'b0, w_bb}) >> 1);
            r_s0_dyn  <= i_s_axis_tuser[0] | i_s_axis_tuser[1];

            r_s1_sqx  <= r_s0_pxm * r_s0_pxm;
            r_s1_sqy  <= r_s0_pym * r_s0_pym;
            r_s1_side <= {r_s0_pxm, r_s0_pym, r_s0_pxn, r_s0_pyn, r_s0_vx, r_s0_vy,
                          r_s0_rsum, r_s0_ia, r_s0_ib, r_s0_tot, r_s0_e, r_s0_dyn};
        end
    end

    // Centre distance
    assign w_sq_ctl = '{en: w_en, vld: r_s1_vld};

    cci_isqrt #(
        .SW (SQS_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sq_ctl),
        .i_rad   (r_s1_sqx + r_s1_sqy),
        .i_side  (r_s1_side),
        .o_vld   (w_sq_vld),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // Hit test, depth and normal dividends
    assign {h_pxm, h_pym, h_pxn, h_pyn, h_vx, h_vy, h_rsum,
            h_ia, h_ib, h_tot, h_e, h_dyn} = w_sq_side;

    assign h_hit    = h_dyn && (h_tot != 32'd0) && (w_root < h_rsum);
    assign h_diff   = h_rsum - w_root;
    assign h_depth  = h_diff[31] ? 31'h7FFF_FFFF : h_diff[30:0];
    assign h_zero   = (h_pxm == 32'd0) && (h_pym == 32'd0);
    assign h_num[0] = {h_pxm, {F{1'b0}}} + NUMW'(w_root >> 1);
    assign h_num[1] = {h_pym, {F{1'b0}}} + NUMW'(w_root >> 1);

    assign w_nd_ctl = '{en: w_en, vld: w_sq_vld};

    cci_div #(
        .LANES (2),
        .NW    (NUMW),
        .DW    (32),
        .QW    (NMW),
        .SW    (NDS_W)
    ) u_ndiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_nd_ctl),
        .i_num   (h_num),
        .i_den   (w_root),
        .i_side  ({h_pxn, h_pyn, h_vx, h_vy, h_ia, h_ib, h_tot, h_e,
                   h_hit, h_depth, h_zero}),
        .o_vld   (w_nd_vld),
        .o_quo   (w_nq),
        .o_side  (w_nd_side)
    );

    // Signed normal, fixed direction for coincident centres, velocity products
    assign {a_pxn, a_pyn, a_vx, a_vy, a_ia, a_ib, a_tot, a_e,
            a_hit, a_depth, a_zero} = w_nd_side;

    assign a_nxm = a_zero ? (NMW'(1) << F) : w_nq[0];
    assign a_nym = a_zero ? '0 : w_nq[1];
    assign a_nx  = $signed(a_pxn ? (NSW'(0) - NSW'(a_nxm)) : NSW'(a_nxm));
    assign a_ny  = $signed(a_pyn ? (NSW'(0) - NSW'(a_nym)) : NSW'(a_nym));
    assign a_sx  = a_vx * a_nx;
    assign a_sy  = a_vy * a_ny;

    // Closing speed magnitude and separation flag
    assign w_s   = SSW'(r_sb_sx) + SSW'(r_sb_sy);
    assign w_su  = w_s;
    assign w_abs = w_su[SSW-1] ? (SSW'(0) - w_su) : w_su;

    // Stages B, C, D
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb_sx    <= a_sx;
            r_sb_sy    <= a_sy;
            r_sb_nx    <= a_nx;
            r_sb_ny    <= a_ny;
            r_sb_nxm   <= a_nxm;
            r_sb_nym   <= a_nym;
            r_sb_ia    <= a_ia;
            r_sb_ib    <= a_ib;
            r_sb_tot   <= a_tot;
            r_sb_e     <= a_e;
            r_sb_hit   <= a_hit;
            r_sb_depth <= a_depth;

            r_sc_v     <= VW'(w_abs >> F);
            r_sc_ef    <= EFW'(r_sb_e) + EFW'(BOUNCE_ONE);
            r_sc_sep   <= (w_s > 0);
            r_sc_nx    <= r_sb_nx;
            r_sc_ny    <= r_sb_ny;
            r_sc_nxm   <= r_sb_nxm;
            r_sc_nym   <= r_sb_nym;
            r_sc_ia    <= r_sb_ia;
            r_sc_ib    <= r_sb_ib;
            r_sc_tot   <= r_sb_tot;
            r_sc_hit   <= r_sb_hit;
            r_sc_depth <= r_sb_depth;

            r_sd_qp    <= r_sc_v * r_sc_ef;
            r_sd_sep   <= r_sc_sep;
            r_sd_nx    <= r_sc_nx;
            r_sd_ny    <= r_sc_ny;
            r_sd_nxm   <= r_sc_nxm;
            r_sd_nym   <= r_sc_nym;
            r_sd_ia    <= r_sc_ia;
            r_sd_ib    <= r_sc_ib;
            r_sd_tot   <= r_sc_tot;
            r_sd_hit   <= r_sc_hit;
            r_sd_depth <= r_sc_depth;
        end
    end

    // Share dividends: depth and impulse, each weighted by both inverse masses
    assign w_q       = r_sd_qp[QPW-1:16];
    assign w_snum[0] = r_sd_depth * r_sd_ia;
    assign w_snum[1] = r_sd_depth * r_sd_ib;
    assign w_snum[2] = w_q * r_sd_ia;
    assign w_snum[3] = w_q * r_sd_ib;

    assign w_sd_ctl = '{en: w_en, vld: r_sd_vld};

    cci_div #(
        .LANES (4),
        .NW    (SHNW),
        .DW    (32),
        .QW    (QQW),
        .SW    (SHS_W)
    ) u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sd_ctl),
        .i_num   (w_snum),
        .i_den   (r_sd_tot),
        .i_side  ({r_sd_nx, r_sd_ny, r_sd_nxm, r_sd_nym, r_sd_hit, r_sd_sep,
                   r_sd_depth}),
        .o_vld   (w_sh_vld),
        .o_quo   (w_g),
        .o_side  (w_sh_side)
    );

    // Project each share onto the normal
    assign {e_nx, e_ny, e_nxm, e_nym, e_hit, e_sep, e_depth} = w_sh_side;

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            w_epx[l] = w_g[l] * e_nxm;
            w_epy[l] = w_g[l] * e_nym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_se_px    <= w_epx;
            r_se_py    <= w_epy;
            r_se_nx    <= e_nx;
            r_se_ny    <= e_ny;
            r_se_hit   <= e_hit;
            r_se_sep   <= e_sep;
            r_se_depth <= e_depth;
        end
    end

    // Scale back, saturate, drop all fields of a miss and the kicks of a separating pair
    assign w_nx32 = 32'(r_se_nx);
    assign w_ny32 = 32'(r_se_ny);

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            w_ox[l] = f_along(MW'(r_se_px[l] >> F), r_se_nx[NSW-1]);
            w_oy[l] = f_along(MW'(r_se_py[l] >> F), r_se_ny[NSW-1]);
            if (!r_se_hit || (l >= 2 && r_se_sep)) begin
                w_ox[l] = '0;
                w_oy[l] = '0;
            end
        end
        if (r_se_hit) begin
            n_out_data = {4'd0, w_oy[3], w_ox[3], w_oy[2], w_ox[2],
                          w_oy[1], w_ox[1], w_oy[0], w_ox[0],
                          w_ny32[17:0], w_nx32[17:0], 1'b0, r_se_depth};
        end else begin
            n_out_data = '0;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out_data;
            r_out_hit  <= r_se_hit;
        end
    end

    assign o_m_axis_tvalid   = r_out_vld;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_hit;

`ifndef SYNTHESIS
    // A miss carries an all-zero payload
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("miss beat with non-zero payload");

    // A hit always has a strictly positive depth
    a_hit_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |->
            (!o_m_axis_tdata[31] && (o_m_axis_tdata[30:0] != 31'd0)))
        else $error("hit beat without positive depth");

    // Reset empties the output stage
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");
`endif

endmodule

// ===== rtl/cci_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on cci_pkg for widths and the stage control struct.
module cci_isqrt
    import cci_pkg::*;
#(
    parameter int SW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_stage_ctl        i_ctl,
    input  logic [RAD_W-1:0]  i_rad,
    input  logic [SW-1:0]     i_side,
    output logic              o_vld,
    output logic [ROOT_W-1:0] o_root,
    output logic [SW-1:0]     o_side
);

    localparam int NS    = ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic [RAD_W-1:0]  r_x    [0:NS-1];
    logic [REM_W-1:0]  r_rem  [0:NS-1];
    logic [ROOT_W-1:0] r_root [0:NS];
    logic [SW-1:0]     r_side [0:NS];
    logic              r_vld  [0:NS];

    logic [RAD_W-1:0]  n_x    [1:NS];
    logic [REM_W-1:0]  n_rem  [1:NS];
    logic [ROOT_W-1:0] n_root [1:NS];

    // One root bit per stage: bring down two radicand bits, try the next digit
    always_comb begin
        logic [REM_W+1:0] sh;
        logic [REM_W+1:0] trial;
        for (int k = 1; k <= NS; k++) begin
            sh     = {r_rem[k-1], r_x[k-1][RAD_W-1 -: 2]};
            trial  = {2'b00, r_root[k-1], 2'b01};
            n_x[k] = r_x[k-1] << 2;
            if (sh >= trial) begin
                n_rem[k]  = REM_W'(sh - trial);
                n_root[k] = {r_root[k-1][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = REM_W'(sh);
                n_root[k] = {r_root[k-1][ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Valid bits travel with the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NS; k++) r_vld[k] <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld[0] <= i_ctl.vld;
            for (int k = 1; k <= NS; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // Advance the working values
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_x[0]    <= i_rad;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
            for (int k = 1; k < NS; k++) begin
                r_x[k]   <= n_x[k];
                r_rem[k] <= n_rem[k];
            end
            for (int k = 1; k <= NS; k++) begin
                r_root[k] <= n_root[k];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_vld  = r_vld[NS];
    assign o_root = r_root[NS];
    assign o_side = r_side[NS];

endmodule

// ===== rtl/cci_div.sv =====
// Pipelined restoring divider, several lanes over one common divisor,
// one quotient bit per stage, with sideband. Depends on cci_pkg.
module cci_div
    import cci_pkg::*;
#(
    parameter int LANES = 2,
    parameter int NW    = 48,
    parameter int DW    = 32,
    parameter int QW    = 17,
    parameter int SW    = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_stage_ctl                 i_ctl,
    input  logic [LANES-1:0][NW-1:0]   i_num,
    input  logic [DW-1:0]              i_den,
    input  logic [SW-1:0]              i_side,
    output logic                       o_vld,
    output logic [LANES-1:0][QW-1:0]   o_quo,
    output logic [SW-1:0]              o_side
);

    logic [LANES-1:0][DW-1:0] r_rem  [0:QW-1];
    logic [LANES-1:0][QW-1:0] r_lo   [0:QW];
    logic [DW-1:0]            r_den  [0:QW-1];
    logic [SW-1:0]            r_side [0:QW];
    logic                     r_vld  [0:QW];

    logic [LANES-1:0][DW-1:0] n_rem  [1:QW];
    logic [LANES-1:0][QW-1:0] n_lo   [1:QW];

    // Shift in one dividend bit, subtract where it fits, shift the quotient bit in
    always_comb begin
        logic [DW:0] sh;
        logic        qbit;
        for (int k = 1; k <= QW; k++) begin
            for (int l = 0; l < LANES; l++) begin
                sh = {r_rem[k-1][l], r_lo[k-1][l][QW-1]};
                if (sh >= {1'b0, r_den[k-1]}) begin
                    n_rem[k][l] = DW'(sh - {1'b0, r_den[k-1]});
                    qbit        = 1'b1;
                end else begin
                    n_rem[k][l] = DW'(sh);
                    qbit        = 1'b0;
                end
                n_lo[k][l] = {r_lo[k-1][l][QW-2:0], qbit};
            end
        end
    end

    // Valid bits travel with the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) r_vld[k] <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld[0] <= i_ctl.vld;
            for (int k = 1; k <= QW; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // Load the upper dividend part as the first partial remainder, then advance
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int l = 0; l < LANES; l++) begin
                r_rem[0][l] <= DW'(i_num[l] >> QW);
                r_lo[0][l]  <= i_num[l][QW-1:0];
            end
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            for (int k = 1; k < QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= r_den[k-1];
            end
            for (int k = 1; k <= QW; k++) begin
                r_lo[k]   <= n_lo[k];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_vld  = r_vld[QW];
    assign o_quo  = r_lo[QW];
    assign o_side = r_side[QW];

endmodule
